### sv/aenc_pkg.sv
`timescale 1ns / 1ps
package aenc_pkg;
  localparam int unsigned SymbolCount   = 257;
  localparam int unsigned PrecisionBits = 31;
  localparam int unsigned CumW          = 30;
  localparam int unsigned SymW          = 9;
  localparam int unsigned CountW        = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_RENORM,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [SymW-1:0] symbol;
    logic [CumW-1:0] cum_low;
    logic [CumW-1:0] cum_high;
  } in_beat_t;

  typedef struct packed {
    logic              lead_bit;
    logic [CountW-1:0] follow_count;
    logic              last;
    logic              error;
  } out_beat_t;
endpackage

### sv/aenc_if.sv
`timescale 1ns / 1ps
interface aenc_in_if;
  logic                valid;
  logic                ready;
  aenc_pkg::in_beat_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aenc_out_if;
  logic                valid;
  logic                ready;
  aenc_pkg::out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/arithmetic_encoder_renorm.sv
`timescale 1ns / 1ps
// Integer binary arithmetic encoder with E1/E2/E3 renormalization. A load
// beat writes one symbol's cumulative bounds into an on-chip table; an encode
// beat narrows the interval with floor(range*cum/total) and then emits one
// output beat per E1/E2 scaling (lead bit plus pending count); a finish beat
// emits the terminating bit, if the interval calls for one, and resets the
// interval. The block handles one input beat at a time and is not ready while
// busy. A load or an unknown opcode passes through the read state and returns
// to idle. An encode runs the shared shift-add/shift-subtract unit once per
// bound, a multiply and then a divide, after the read and fetch states and
// before the check state; then it runs the renormalization steps and releases
// the final beat. An encode of an out-of-range symbol skips the arithmetic.
// Each scaling beat is staged one step so that the final one can carry last;
// a step that must hand a beat to a held output register stalls until the
// sink takes it. Finish waits for the output register to be free. The user
// must see that total_count is written only while idle; the block does not
// enforce it. Zero total_count is treated as one.
module arithmetic_encoder_renorm #(
  parameter int unsigned SYMBOL_COUNT   = aenc_pkg::SymbolCount,
  parameter int unsigned PRECISION_BITS = aenc_pkg::PrecisionBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [aenc_pkg::CumW-1:0] cfg_wdata_i,
  aenc_in_if.sink                   in_if,
  aenc_out_if.source                out_if
);
  localparam int unsigned PW   = PRECISION_BITS + 1;
  localparam int unsigned CW   = aenc_pkg::CumW;
  localparam int unsigned AW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned PRW  = PW + CW;
  localparam int unsigned ITW  = $clog2(PRW + 1);
  localparam int unsigned MIW  = $clog2(PW);
  localparam logic [PW-1:0] Full    = PW'(1) << PRECISION_BITS;
  localparam logic [PW-1:0] Half    = Full >> 1;
  localparam logic [PW-1:0] Quarter = Full >> 2;
  localparam logic [PW-1:0] ThreeQ  = Half + Quarter;
  localparam logic [31:0]   PendMax = '1;
  localparam logic [1:0]    ActNone = 2'd0;
  localparam logic [1:0]    ActE1   = 2'd1;
  localparam logic [1:0]    ActE2   = 2'd2;
  localparam logic [1:0]    ActE3   = 2'd3;

  aenc_pkg::state_e state_q, state_d;

  logic [CW-1:0]   total_q;
  logic [PW-1:0]   low_q, low_d, high_q, high_d;
  logic [31:0]     pend_q, pend_d;

  // symbol table
  logic [2*CW-1:0] tab_mem [SYMBOL_COUNT];
  logic [2*CW-1:0] tab_rd_q;

  aenc_pkg::in_beat_t in_q;
  logic              sym_ok;

  // shared shift-add/shift-subtract unit: product then quotient
  logic [CW-1:0]   divisor;
  logic [CW-1:0]   cl_q, ch_q;
  logic            pass_q, pass_d;     // 0 low bound, 1 high bound
  logic [PRW-1:0]  prod_q, prod_d;
  logic [CW:0]     rem_q, rem_d;
  logic [PRW-1:0]  quo_q, quo_d;
  logic [ITW-1:0]  cnt_q, cnt_d;
  logic [PW-1:0]   add_lo_q, add_lo_d;
  logic [CW-1:0]   mcand;
  logic [CW:0]     rem_sh;
  logic [PW-1:0]   rng;
  logic [MIW-1:0]  mul_idx;

  aenc_pkg::out_beat_t ob_q, ob_d;
  logic                ov_q, ov_d;
  aenc_pkg::out_beat_t stg_q, stg_d;
  logic                stg_vld_q, stg_vld_d;

  assign divisor = (total_q == '0) ? CW'(1) : total_q;
  assign sym_ok  = ({{(32 - aenc_pkg::SymW){1'b0}}, in_q.symbol} < 32'(SYMBOL_COUNT));
  assign rng     = high_q - low_q;
  assign mcand   = pass_q ? ch_q : cl_q;
  assign rem_sh  = {rem_q[CW-1:0], quo_q[PRW-1]};
  assign mul_idx = MIW'(cnt_q - ITW'(1));

  assign in_if.ready    = (state_q == aenc_pkg::ST_IDLE);
  assign out_if.valid   = ov_q;
  assign out_if.payload = ob_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= CW'(1);
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (state_q == aenc_pkg::ST_READ && in_q.opcode == aenc_pkg::OP_LOAD && sym_ok) begin
      tab_mem[AW'(in_q.symbol)] <= {in_q.cum_high, in_q.cum_low};
    end
    tab_rd_q <= tab_mem[AW'(in_q.symbol)];
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_q <= in_if.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aenc_pkg::ST_IDLE;
      low_q     <= '0;
      high_q    <= Full;
      pend_q    <= '0;
      ov_q      <= 1'b0;
      stg_vld_q <= 1'b0;
      pass_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      low_q     <= low_d;
      high_q    <= high_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
      stg_vld_q <= stg_vld_d;
      pass_q    <= pass_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q     <= ob_d;
    stg_q    <= stg_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    add_lo_q <= add_lo_d;
    if (state_q == aenc_pkg::ST_FETCH) begin
      cl_q <= (tab_rd_q[CW-1:0] > divisor) ? divisor : tab_rd_q[CW-1:0];
      ch_q <= (tab_rd_q[2*CW-1:CW] > divisor) ? divisor : tab_rd_q[2*CW-1:CW];
    end
  end

  // sequencer
  always_comb begin
    logic [PW-1:0] add_hi;
    logic [PW-1:0] step_lo, step_hi;
    logic [31:0]   fin_follow;
    logic [1:0]    act;
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    pend_d    = pend_q;
    ov_d      = ov_q;
    ob_d      = ob_q;
    stg_d     = stg_q;
    stg_vld_d = stg_vld_q;
    pass_d    = pass_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    add_lo_d  = add_lo_q;
    add_hi    = quo_q[PW-1:0];
    fin_follow = (pend_q == PendMax) ? PendMax : pend_q + 32'd1;

    // classify the next scaling step
    step_lo = '0;
    step_hi = '0;
    act     = ActNone;
    if (high_q <= Half) begin
      act = ActE1; step_lo = low_q << 1; step_hi = high_q << 1;
    end else if (low_q >= Half) begin
      act = ActE2; step_lo = (low_q << 1) - Full; step_hi = (high_q << 1) - Full;
    end else if (high_q <= ThreeQ && low_q >= Quarter) begin
      act = ActE3; step_lo = (low_q << 1) - Half; step_hi = (high_q << 1) - Half;
    end

    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      aenc_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_d = aenc_pkg::ST_READ;
        end
      end
      aenc_pkg::ST_READ: begin
        case (in_q.opcode)
          aenc_pkg::OP_ENCODE: state_d = aenc_pkg::ST_FETCH;
          aenc_pkg::OP_FINISH: state_d = aenc_pkg::ST_FINISH;
          default:             state_d = aenc_pkg::ST_IDLE;
        endcase
      end
      aenc_pkg::ST_FETCH: begin
        if (!sym_ok) begin
          state_d = aenc_pkg::ST_CHECK;
          add_lo_d = PW'(1);
          quo_d   = '0;
        end else begin
          pass_d  = 1'b0;
          cnt_d   = ITW'(PW);
          prod_d  = '0;
          state_d = aenc_pkg::ST_MUL;
        end
      end
      // shift-add multiply range*cum, one range bit per cycle
      aenc_pkg::ST_MUL: begin
        if (cnt_q == '0) begin
          quo_d   = prod_q;
          rem_d   = '0;
          cnt_d   = ITW'(PRW);
          state_d = aenc_pkg::ST_DIV;
        end else begin
          prod_d = (prod_q << 1) +
                   (rng[mul_idx] ? PRW'(mcand) : PRW'(0));
          cnt_d  = cnt_q - ITW'(1);
        end
      end
      // restoring divide by total, one quotient bit per cycle
      aenc_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          if (!pass_q) begin
            add_lo_d = quo_q[PW-1:0];
            pass_d   = 1'b1;
            cnt_d    = ITW'(PW);
            prod_d   = '0;
            state_d  = aenc_pkg::ST_MUL;
          end else begin
            state_d = aenc_pkg::ST_CHECK;
          end
        end else begin
          if (rem_sh >= {1'b0, divisor}) begin
            rem_d = rem_sh - {1'b0, divisor};
            quo_d = {quo_q[PRW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[PRW-2:0], 1'b0};
          end
          cnt_d = cnt_q - ITW'(1);
        end
      end
      // empty interval gives a lone error beat once the output is free
      aenc_pkg::ST_CHECK: begin
        if (add_hi <= add_lo_q) begin
          if (!ov_d) begin
            ob_d    = '{lead_bit: 1'b0, follow_count: '0, last: 1'b1, error: 1'b1};
            ov_d    = 1'b1;
            state_d = aenc_pkg::ST_IDLE;
          end
        end else begin
          high_d  = low_q + add_hi;
          low_d   = low_q + add_lo_q;
          state_d = aenc_pkg::ST_RENORM;
        end
      end
      // one scaling step per cycle unless a beat waits on the held output, each scaling beat staged one step
      aenc_pkg::ST_RENORM: begin
        case (act)
          ActE1, ActE2: begin
            if (!stg_vld_q || !ov_d) begin
              if (stg_vld_q) begin
                ob_d = stg_q;
                ov_d = 1'b1;
              end
              stg_d     = '{lead_bit: (act == ActE2), follow_count: pend_q,
                            last: 1'b0, error: 1'b0};
              stg_vld_d = 1'b1;
              low_d     = step_lo;
              high_d    = step_hi;
              pend_d    = '0;
            end
          end
          ActE3: begin
            low_d  = step_lo;
            high_d = step_hi;
            if (pend_q != PendMax) pend_d = pend_q + 32'd1;
          end
          default: begin
            // release the staged beat as the final one
            if (!stg_vld_q) begin
              state_d = aenc_pkg::ST_IDLE;
            end else if (!ov_d) begin
              ob_d      = stg_q;
              ob_d.last = 1'b1;
              ov_d      = 1'b1;
              stg_vld_d = 1'b0;
              state_d   = aenc_pkg::ST_IDLE;
            end
          end
        endcase
      end
      aenc_pkg::ST_FINISH: begin
        if (!ov_d) begin
          if (low_q < Quarter && high_q > Half) begin
            ob_d = '{lead_bit: 1'b0, follow_count: fin_follow, last: 1'b1, error: 1'b0};
            ov_d = 1'b1;
          end else if (low_q >= Quarter && low_q < Half && high_q >= ThreeQ) begin
            ob_d = '{lead_bit: 1'b1, follow_count: fin_follow, last: 1'b1, error: 1'b0};
            ov_d = 1'b1;
          end
          low_d   = '0;
          high_d  = Full;
          pend_d  = '0;
          state_d = aenc_pkg::ST_IDLE;
        end
      end
      default: state_d = aenc_pkg::ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("output beat dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.payload))
    else $error("output beat changed while held");
  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == aenc_pkg::ST_RENORM |-> high_q > low_q)
    else $error("empty interval during renorm");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != aenc_pkg::ST_IDLE |-> !in_if.ready)
    else $error("ready while busy");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == aenc_pkg::ST_IDLE |-> !stg_vld_q)
    else $error("staged beat left behind");
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  localparam logic [63:0] FullScale = 64'd1 << aenc_pkg::PrecisionBits;
  localparam logic [63:0] Half      = FullScale >> 1;
  localparam logic [63:0] Quarter   = FullScale >> 2;
  localparam logic [63:0] ThreeQ    = 3 * (FullScale >> 2);
  localparam logic [31:0] PendMax   = 32'hFFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [aenc_pkg::CumW-1:0] cfg_wdata_i;

  aenc_in_if  in_if ();
  aenc_out_if out_if ();

  arithmetic_encoder_renorm dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // predictor state
  logic [63:0] pr_low, pr_high, pr_total;
  logic [31:0] pr_pend;
  logic [aenc_pkg::CumW-1:0] tab_lo [aenc_pkg::SymbolCount];
  logic [aenc_pkg::CumW-1:0] tab_hi [aenc_pkg::SymbolCount];
  aenc_pkg::out_beat_t bits_expected[$];

  int errors;
  int mismatches;
  int hold_cycles;
  int long_hold;
  bit no_gaps;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic aenc_pkg::out_beat_t mk_beat(logic b, logic [31:0] f);
    aenc_pkg::out_beat_t r;
    r.lead_bit = b;
    r.follow_count = f;
    r.last = 1'b0;
    r.error = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] scale_by(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    return (a / d) * b + ((a % d) * b) / d;
  endfunction

  // interval narrowing plus renormalization, queues expected beats
  function automatic void predict(aenc_pkg::in_beat_t it);
    logic [63:0] d, cl, ch, alo, ahi, rng;
    aenc_pkg::out_beat_t r;
    aenc_pkg::out_beat_t res[$];
    d = (pr_total == 0) ? 64'd1 : pr_total;
    case (aenc_pkg::op_e'(it.opcode))
      aenc_pkg::OP_LOAD: begin
        if (it.symbol < aenc_pkg::SymbolCount) begin
          tab_lo[it.symbol] = it.cum_low;
          tab_hi[it.symbol] = it.cum_high;
        end
      end
      aenc_pkg::OP_ENCODE: begin
        if (it.symbol >= aenc_pkg::SymbolCount) begin
          alo = 1;
          ahi = 0;
        end else begin
          cl = tab_lo[it.symbol];
          ch = tab_hi[it.symbol];
          if (cl > d) cl = d;
          if (ch > d) ch = d;
          rng = pr_high - pr_low;
          alo = scale_by(rng, cl, d);
          ahi = scale_by(rng, ch, d);
        end
        if (ahi <= alo) begin
          r.lead_bit = 1'b0;
          r.follow_count = '0;
          r.last = 1'b1;
          r.error = 1'b1;
          res = {res, r};
        end else begin
          pr_high = pr_low + ahi;
          pr_low = pr_low + alo;
          forever begin
            if (pr_high <= Half) begin
              pr_low = pr_low << 1;
              pr_high = pr_high << 1;
              res = {res, mk_beat(1'b0, pr_pend)};
              pr_pend = 0;
            end else if (pr_low >= Half) begin
              pr_low = 2 * pr_low - FullScale;
              pr_high = 2 * pr_high - FullScale;
              res = {res, mk_beat(1'b1, pr_pend)};
              pr_pend = 0;
            end else if (pr_high <= ThreeQ && pr_low >= Quarter) begin
              pr_low = 2 * pr_low - Half;
              pr_high = 2 * pr_high - Half;
              if (pr_pend != PendMax) pr_pend++;
            end else begin
              break;
            end
          end
          if (res.size() > 0) begin
            r = res[res.size() - 1];
            r.last = 1'b1;
            res[res.size() - 1] = r;
          end
        end
      end
      aenc_pkg::OP_FINISH: begin
        if (pr_low < Quarter && pr_high > Half) begin
          r = mk_beat(1'b0, (pr_pend == PendMax) ? PendMax : pr_pend + 32'd1);
          r.last = 1'b1;
          res = {res, r};
        end else if (pr_low >= Quarter && pr_low < Half && pr_high >= ThreeQ) begin
          r = mk_beat(1'b1, (pr_pend == PendMax) ? PendMax : pr_pend + 32'd1);
          r.last = 1'b1;
          res = {res, r};
        end
        pr_low = 0;
        pr_high = FullScale;
        pr_pend = 0;
      end
      default: ;
    endcase
    bits_expected = {bits_expected, res};
  endfunction

  function automatic int rand_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one beat, predicting at acceptance; valid stays up for a following beat
  task automatic send_beat(aenc_pkg::op_e op, logic [aenc_pkg::SymW-1:0] sym,
                           logic [aenc_pkg::CumW-1:0] lo, logic [aenc_pkg::CumW-1:0] hi);
    aenc_pkg::in_beat_t it;
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.opcode = op;
    it.symbol = sym;
    it.cum_low = lo;
    it.cum_high = hi;
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    predict(it);
  endtask

  // wait for all results and an idle block before a register write
  task automatic drain();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while ((bits_expected.size() != 0 || !in_if.ready) && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_total(logic [aenc_pkg::CumW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pr_total = v;
  endtask

  task automatic load_sym(logic [aenc_pkg::SymW-1:0] s, logic [aenc_pkg::CumW-1:0] lo,
                          logic [aenc_pkg::CumW-1:0] hi);
    send_beat(aenc_pkg::OP_LOAD, s, lo, hi);
  endtask

  // uniform-ish table over the current total
  task automatic load_table(int count);
    logic [63:0] step;
    step = pr_total / count;
    if (step == 0) step = 1;
    for (int s = 0; s < count; s++) begin
      load_sym(s[aenc_pkg::SymW-1:0], aenc_pkg::CumW'(s * step),
               aenc_pkg::CumW'((s + 1) * step));
    end
    load_sym(9'd256, aenc_pkg::CumW'(count * step), aenc_pkg::CumW'(pr_total));
  endtask

  task automatic test_directed();
    write_total(30'd16);
    load_sym(9'd0, 30'd0, 30'd1);
    load_sym(9'd1, 30'd1, 30'd15);
    load_sym(9'd2, 30'd15, 30'd16);
    load_sym(9'd3, 30'd5, 30'd5);          // zero width
    load_sym(9'd4, 30'd9, 30'd3);          // inverted
    load_sym(9'd5, 30'h3FFF_FFFF, 30'h3FFF_FFFF); // above total
    load_sym(9'd6, 30'd0, 30'h3FFF_FFFF);
    load_sym(9'd256, 30'd7, 30'd9);
    load_sym(9'h1FF, 30'h2AAA_AAAA, 30'h1555_5555); // out of range load
    send_beat(aenc_pkg::OP_ENCODE, 9'd0, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd2, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd1, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd3, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd4, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd5, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd6, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd300, '0, '0);
    send_beat(aenc_pkg::OP_ENCODE, 9'h1FF, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
    send_beat(aenc_pkg::OP_ENCODE, 9'd256, '0, '0);
    send_beat(aenc_pkg::OP_NONE, 9'd1, '0, '0);
    send_beat(aenc_pkg::OP_FINISH, '0, '0, '0);
    send_beat(aenc_pkg::OP_FINISH, '0, '0, '0);
    // zero total behaves as one
    write_total(30'd0);
    send_beat(aenc_pkg::OP_ENCODE, 9'd6, '0, '0);
    send_beat(aenc_pkg::OP_FINISH, '0, '0, '0);
  endtask

  // pending count growth: symbol straddling the midpoint repeatedly
  task automatic test_pending();
    write_total(30'd1000);
    load_sym(9'd10, 30'd499, 30'd501);
    load_sym(9'd11, 30'd0, 30'd1000);
    for (int i = 0; i < 8; i++) send_beat(aenc_pkg::OP_ENCODE, 9'd10, '0, '0);
    send_beat(aenc_pkg::OP_FINISH, '0, '0, '0);
  endtask

  task automatic random_phase(int items, int syms);
    int k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        send_beat(aenc_pkg::OP_ENCODE, ($urandom_range(0, 19) == 0) ? 9'd256
                  : 9'($urandom_range(0, syms - 1)), aenc_pkg::CumW'($urandom),
                  aenc_pkg::CumW'($urandom));
      end else if (k < 88) begin
        send_beat(aenc_pkg::OP_FINISH, 9'($urandom), aenc_pkg::CumW'($urandom),
                  aenc_pkg::CumW'($urandom));
      end else if (k < 94) begin
        send_beat(aenc_pkg::OP_ENCODE, 9'($urandom_range(aenc_pkg::SymbolCount, 511)),
                  aenc_pkg::CumW'($urandom), aenc_pkg::CumW'($urandom));
      end else if (k < 97) begin
        send_beat(aenc_pkg::OP_NONE, 9'($urandom), aenc_pkg::CumW'($urandom),
                  aenc_pkg::CumW'($urandom));
      end else begin
        load_sym(9'($urandom_range(0, syms - 1)),
                 aenc_pkg::CumW'($urandom_range(0, 32'(pr_total))),
                 aenc_pkg::CumW'($urandom_range(0, 32'(pr_total))));
      end
    end
    send_beat(aenc_pkg::OP_FINISH, '0, '0, '0);
  endtask

  task automatic test_random();
    write_total(30'd23);
    load_table(8);
    random_phase(110, 8);
    write_total(30'd536870912);
    load_table(16);
    load_sym(9'd3, 30'd0, 30'd1);       // tiny interval, many scalings
    random_phase(110, 16);
    write_total(30'h3FFF_FFFF);
    load_table(4);
    no_gaps = 1'b1;
    random_phase(60, 4);
    no_gaps = 1'b0;
  endtask

  // receiver stalls long while the sender keeps offering
  task automatic test_backpressure();
    write_total(30'd1024);
    load_sym(9'd20, 30'd0, 30'd1);
    long_hold = 1;
    for (int i = 0; i < 6; i++) send_beat(aenc_pkg::OP_ENCODE, 9'd20, '0, '0);
    send_beat(aenc_pkg::OP_FINISH, '0, '0, '0);
  endtask

  // sink side: random ready, with an occasional long hold
  initial begin
    out_if.ready <= 1'b0;
    hold_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 0;
        hold_cycles = 600;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (no_gaps) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 60) == 0) hold_cycles = $urandom_range(10, 50);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    aenc_pkg::out_beat_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (bits_expected.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected beat: %p", got);
        mismatches++;
      end else begin
        want = bits_expected.pop_front();
        if (got.lead_bit !== want.lead_bit || got.follow_count !== want.follow_count ||
            got.last !== want.last || got.error !== want.error) begin
          errors++;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
          mismatches++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    mismatches = 0;
    long_hold = 0;
    no_gaps = 1'b0;
    pr_low = 0;
    pr_high = FullScale;
    pr_pend = 0;
    pr_total = 1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pending();
    test_backpressure();
    test_random();
    drain();
    if (bits_expected.size() != 0) errors += bits_expected.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### filelist.f
sv/aenc_pkg.sv
sv/aenc_if.sv
sv/arithmetic_encoder_renorm.sv
bench/tb.sv
